FILE: sv/nms_pkg.sv
// Shared types and constants for the 3x3 non-maximum suppression block.
// Used by every module of the block; depends on nothing else.

package nms_pkg;

  // Coordinate and geometry widths.
  localparam int COL_BITS    = 10;
  localparam int ROW_BITS    = 12;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int IN_ROW_BITS = 13;
  localparam int COL_LIMIT   = 1024;
  localparam int ROW_LIMIT   = 4096;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 32;

  // Configuration port.
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_DROP_PLATEAUS = 2'd2;

  localparam logic [WIDTH_BITS-1:0]  RESET_IMAGE_WIDTH  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] RESET_IMAGE_HEIGHT = 13'd480;

  // Input beat kinds.
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // Which window edges lie outside the image for the judged pixel.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } nms_border_t;

  // Per-column comparison flags against the centre pixel.
  typedef struct packed {
    logic higher;
    logic lower;
  } nms_cmp_t;

  // Bookkeeping that travels with a judged pixel down the pipeline.
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
    nms_border_t         border;
  } nms_meta_t;

endpackage

FILE: sv/nms_line_buf.sv
// Two-row line buffer: one memory word holds the upper and middle row values
// of one column. Depends on nms_pkg.

module nms_line_buf import nms_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int DEPTH      = DEF_MAX_WIDTH,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic signed [PIXEL_BITS-1:0] wr_upper,
  input  logic signed [PIXEL_BITS-1:0] wr_middle,
  output logic signed [PIXEL_BITS-1:0] rd_upper,
  output logic signed [PIXEL_BITS-1:0] rd_middle
);

  logic [2*PIXEL_BITS-1:0] mem [DEPTH];
  logic [2*PIXEL_BITS-1:0] rd_word;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_upper, wr_middle};
    end
  end

  // Registered read port; a write to the same column in the same cycle
  // is forwarded so a one-pixel-wide image still sees fresh data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_word <= {wr_upper, wr_middle};
      end else begin
        rd_word <= mem[rd_addr];
      end
    end
  end

  assign rd_upper  = rd_word[2*PIXEL_BITS-1:PIXEL_BITS];
  assign rd_middle = rd_word[PIXEL_BITS-1:0];

endmodule

FILE: sv/nms_win_cell.sv
// One column of the 3x3 window: holds three pixels, hands them to its left
// neighbor on each shift and compares them against the centre pixel.
// Depends on nms_pkg.

module nms_win_cell import nms_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  parameter int POS        = 0
) (
  input  logic                         clk,
  input  logic                         shift,
  input  logic signed [PIXEL_BITS-1:0] col_in  [3],
  output logic signed [PIXEL_BITS-1:0] col_out [3],
  input  logic signed [PIXEL_BITS-1:0] centre,
  input  nms_border_t                  border,
  output nms_cmp_t                     cmp
);

  logic [2:0] row_ok;
  logic       col_ok;

  // Column storage, loaded from the right-hand neighbor or, in the rightmost cell, from the new column.
  always_ff @(posedge clk) begin
    if (shift) begin
      col_out <= col_in;
    end
  end

  // Rows and columns outside the image do not take part; the centre pixel
  // is never compared with itself.
  always_comb begin
    row_ok[0] = !border.top;
    row_ok[1] = (POS != 1);
    row_ok[2] = !border.bottom;
    if (POS == 0) begin
      col_ok = !border.left;
    end else if (POS == 2) begin
      col_ok = !border.right;
    end else begin
      col_ok = 1'b1;
    end
  end

  // Compare the three held pixels against the centre.
  always_comb begin
    cmp = '0;
    for (int r = 0; r < 3; r++) begin
      if (col_ok && row_ok[r]) begin
        if (col_out[r] > centre) cmp.higher = 1'b1;
        if (col_out[r] < centre) cmp.lower  = 1'b1;
      end
    end
  end

endmodule

FILE: sv/nonmax_suppression_3x3.sv
// Top level of the 3x3 non-maximum suppression block: counters, line buffer,
// window cells and output register. Depends on nms_pkg, nms_line_buf and
// nms_win_cell.
//
// Usage:
//   Input beats (in_valid/in_ready) carry action and pixel_value. Pixels come
//   in raster order; a flush beat (action = 1) after the last pixel of a frame
//   pushes out the results still held back. A flush while pixels are still
//   expected is taken and dropped; a pixel after the last one acts as a flush.
//   Each result beat (out_valid/out_ready) judges one centre pixel: is_peak,
//   its out_row and out_col, and frame_done on the frame's last pixel.
//   Results lag the input by one row plus one pixel, so a frame needs
//   image_width + 1 flush beats after its last pixel.
//   A result moves from its completing beat through the stage 1 registers and
//   the window into the output register. Throughput: one beat per cycle when
//   not stalled: a beat's line buffer read, the previous beat's write-back
//   and the window shift all take place in the same cycle.
//   A stalled receiver holds the output register and stalls the whole
//   pipeline, so in_ready drops for as long as out_ready is low with a
//   result waiting.
//   Reset clears the counters and pipeline and loads 640 x 480, plateaus
//   kept. Writing image_width or image_height restarts the frame. The line
//   buffer is not cleared; border masking keeps stale entries out of results.

module nonmax_suppression_3x3 import nms_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // Pixel input.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic signed [PIXEL_BITS-1:0] pixel_value,
  // Result output.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_peak,
  output logic [ROW_BITS-1:0]          out_row,
  output logic [COL_BITS-1:0]          out_col,
  output logic                         frame_done,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  localparam int LB_DEPTH = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
  localparam int LB_AW    = (LB_DEPTH > 1) ? $clog2(LB_DEPTH) : 1;
  localparam logic [WIDTH_BITS-1:0] W_LIMIT = WIDTH_BITS'(LB_DEPTH);
  localparam logic [HEIGHT_BITS-1:0] H_LIMIT = HEIGHT_BITS'(ROW_LIMIT);

  // Configuration registers.
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic                   drop_plateaus;
  logic                   cfg_wr;
  logic                   geom_wr;

  // Effective geometry.
  logic [WIDTH_BITS-1:0]  eff_w;
  logic [HEIGHT_BITS-1:0] eff_h;

  // Input and result position counters.
  logic [IN_ROW_BITS-1:0] in_row;
  logic [COL_BITS-1:0]    in_col;
  logic [ROW_BITS-1:0]    emit_row;
  logic [COL_BITS-1:0]    emit_col;

  // Stage 0 decode.
  logic        adv;
  logic        accept;
  logic        draining;
  logic        step;
  logic        emit;
  logic        col_wrap;
  logic        cc_last;
  logic        cr_last;
  nms_meta_t   meta0;

  // Stage 1: line buffer read in flight.
  logic                         s1_valid;
  logic                         s1_emit;
  logic signed [PIXEL_BITS-1:0] s1_key;
  logic [LB_AW-1:0]             s1_addr;
  nms_meta_t                    s1_meta;

  // Stage 2: window loaded, ready to judge.
  logic      s2_valid;
  nms_meta_t s2_meta;

  // Line buffer and window.
  logic signed [PIXEL_BITS-1:0] rd_upper;
  logic signed [PIXEL_BITS-1:0] rd_middle;
  logic signed [PIXEL_BITS-1:0] new_col  [3];
  logic signed [PIXEL_BITS-1:0] col_r    [3];
  logic signed [PIXEL_BITS-1:0] col_c    [3];
  logic signed [PIXEL_BITS-1:0] col_l    [3];
  logic                         win_shift;
  nms_cmp_t                     cmp_l;
  nms_cmp_t                     cmp_c;
  nms_cmp_t                     cmp_r;
  logic                         peak;

  // ---------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign geom_wr = cfg_wr && ((paddr[3:2] == REG_IMAGE_WIDTH) ||
                              (paddr[3:2] == REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RESET_IMAGE_WIDTH;
      image_height  <= RESET_IMAGE_HEIGHT;
      drop_plateaus <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_WIDTH:   image_width   <= pwdata[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT:  image_height  <= pwdata[HEIGHT_BITS-1:0];
        REG_DROP_PLATEAUS: drop_plateaus <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_WIDTH:   prdata = APB_DATA_BITS'(image_width);
      REG_IMAGE_HEIGHT:  prdata = APB_DATA_BITS'(image_height);
      REG_DROP_PLATEAUS: prdata = APB_DATA_BITS'(drop_plateaus);
      default:           prdata = '0;
    endcase
  end

  // Clamp the geometry to what the block supports.
  always_comb begin
    eff_w = image_width;
    if (eff_w == '0)     eff_w = WIDTH_BITS'(1);
    if (eff_w > W_LIMIT) eff_w = W_LIMIT;
    eff_h = image_height;
    if (eff_h == '0)     eff_h = HEIGHT_BITS'(1);
    if (eff_h > H_LIMIT) eff_h = H_LIMIT;
  end

  // ---------------------------------------------------------------------
  // Stage 0: accept a beat and advance the position counters.
  // ---------------------------------------------------------------------
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;
  assign draining = in_row >= IN_ROW_BITS'(eff_h);
  assign step     = accept && (draining || (action == ACT_PIXEL));
  assign emit     = (in_row >= IN_ROW_BITS'(2)) ||
                    ((in_row == IN_ROW_BITS'(1)) && (in_col != '0));
  assign col_wrap = ({1'b0, in_col} + WIDTH_BITS'(1)) >= eff_w;
  assign cc_last  = ({1'b0, emit_col} + WIDTH_BITS'(1)) >= eff_w;
  assign cr_last  = ({1'b0, emit_row} + HEIGHT_BITS'(1)) >= eff_h;

  always_comb begin
    meta0.row           = emit_row;
    meta0.col           = emit_col;
    meta0.last          = cr_last && cc_last;
    meta0.border.top    = (emit_row == '0);
    meta0.border.bottom = cr_last;
    meta0.border.left   = (emit_col == '0);
    meta0.border.right  = cc_last;
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      in_row   <= '0;
      in_col   <= '0;
      emit_row <= '0;
      emit_col <= '0;
    end else if (step) begin
      if (emit && meta0.last) begin
        // Frame complete: next pixel starts a new frame.
        in_row   <= '0;
        in_col   <= '0;
        emit_row <= '0;
        emit_col <= '0;
      end else begin
        if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + IN_ROW_BITS'(1);
        end else begin
          in_col <= in_col + COL_BITS'(1);
        end
        if (emit) begin
          if (cc_last) begin
            emit_col <= '0;
            emit_row <= emit_row + ROW_BITS'(1);
          end else begin
            emit_col <= emit_col + COL_BITS'(1);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: line buffer read returns; write back the shifted column.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_emit <= emit;
      s1_key  <= pixel_value;
      s1_addr <= LB_AW'(in_col);
      s1_meta <= meta0;
    end
  end

  nms_line_buf #(
    .PIXEL_BITS (PIXEL_BITS),
    .DEPTH      (LB_DEPTH)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (step),
    .rd_addr   (LB_AW'(in_col)),
    .wr_en     (win_shift),
    .wr_addr   (s1_addr),
    .wr_upper  (rd_middle),
    .wr_middle (s1_key),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  assign win_shift = adv && s1_valid;

  always_comb begin
    new_col[0] = rd_upper;
    new_col[1] = rd_middle;
    new_col[2] = s1_key;
  end

  // ---------------------------------------------------------------------
  // Window: three column cells, newest on the right.
  // ---------------------------------------------------------------------
  nms_win_cell #(.PIXEL_BITS(PIXEL_BITS), .POS(2)) u_cell_r (
    .clk     (clk),
    .shift   (win_shift),
    .col_in  (new_col),
    .col_out (col_r),
    .centre  (col_c[1]),
    .border  (s2_meta.border),
    .cmp     (cmp_r)
  );

  nms_win_cell #(.PIXEL_BITS(PIXEL_BITS), .POS(1)) u_cell_c (
    .clk     (clk),
    .shift   (win_shift),
    .col_in  (col_r),
    .col_out (col_c),
    .centre  (col_c[1]),
    .border  (s2_meta.border),
    .cmp     (cmp_c)
  );

  nms_win_cell #(.PIXEL_BITS(PIXEL_BITS), .POS(0)) u_cell_l (
    .clk     (clk),
    .shift   (win_shift),
    .col_in  (col_c),
    .col_out (col_l),
    .centre  (col_c[1]),
    .border  (s2_meta.border),
    .cmp     (cmp_l)
  );

  // ---------------------------------------------------------------------
  // Stage 2: judge the centre and load the output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (win_shift) begin
      s2_meta <= s1_meta;
    end
  end

  assign peak = !(cmp_l.higher || cmp_c.higher || cmp_r.higher) &&
                (!drop_plateaus || cmp_l.lower || cmp_c.lower || cmp_r.lower);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      is_peak    <= peak;
      out_row    <= s2_meta.row;
      out_col    <= s2_meta.col;
      frame_done <= s2_meta.last;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // The input column always lies inside the current row.
  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_col} < eff_w)
    else $error("input column outside image width");

  // Draining never runs more than one row past the frame.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_row} <= ({1'b0, eff_h} + (IN_ROW_BITS + 1)'(1)))
    else $error("input row ran past the drain window");

  // When the last result of a frame is shown, the result counters restarted.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> ((emit_row == '0) && (emit_col == '0)))
    else $error("result counters not restarted after frame end");

  // A waiting result stalls the input side.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while a result is stalled");

endmodule
